// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl_, clk_, rst_n_, cond_, msg_) \
  lbl_: assert property (@(posedge clk_) disable iff (!rst_n_) (cond_)) else $error(msg_);

// Same-cycle implication
`define ASSERT_IMPLIES(lbl_, clk_, rst_n_, ante_, cons_, msg_) \
  lbl_: assert property (@(posedge clk_) disable iff (!rst_n_) (ante_) |-> (cons_)) \
    else $error(msg_);

// Next-cycle implication
`define ASSERT_NEXT(lbl_, clk_, rst_n_, ante_, cons_, msg_) \
  lbl_: assert property (@(posedge clk_) disable iff (!rst_n_) (ante_) |=> (cons_)) \
    else $error(msg_);

`else

`define ASSERT_ALWAYS(lbl_, clk_, rst_n_, cond_, msg_)
`define ASSERT_IMPLIES(lbl_, clk_, rst_n_, ante_, cons_, msg_)
`define ASSERT_NEXT(lbl_, clk_, rst_n_, ante_, cons_, msg_)

`endif

`endif

// File: rtl/mtb_pkg.sv
// ---------------------------------------------------------------------------
// mtb_pkg
// Shared widths, codes and types of the timer bank.
// ---------------------------------------------------------------------------
package mtb_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 16;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned DUR_W    = 31;
  localparam int unsigned STEP_W   = 20;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned SLOT_FW  = 4;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [SLOT_FW-1:0]  slot_fld_t;
  typedef logic [DUR_W-1:0]    dur_t;
  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [STEP_W-1:0]   step_t;

  localparam step_t STEP_RST = 20'd1000;

  localparam mode_t MODE_CREATE = 3'd0;
  localparam mode_t MODE_START  = 3'd1;
  localparam mode_t MODE_STOP   = 3'd2;
  localparam mode_t MODE_FREE   = 3'd3;
  localparam mode_t MODE_TICK   = 3'd4;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_ERR     = 2'd1;
  localparam status_t ST_EXPIRED = 2'd2;
  localparam status_t ST_DONE    = 2'd3;

  localparam kind_t KIND_ONE_SHOT  = 2'd0;
  localparam kind_t KIND_AUTO_FREE = 2'd1;
  localparam kind_t KIND_LOOP      = 2'd2;

  typedef struct packed {
    time_t expiry;
    dur_t  interval;
  } timer_ent_t;

  typedef struct packed {
    logic       kind_we;
    logic       tmr_we;
    kind_t      kind;
    timer_ent_t tmr;
  } slot_wr_t;

endpackage

// File: rtl/mtb_ifs.sv
// ---------------------------------------------------------------------------
// Timer bank channels
// Request, result and configuration handshake channels.
// ---------------------------------------------------------------------------
interface mtb_cmd_if;
  logic                valid;
  logic                ready;
  mtb_pkg::mode_t      mode;
  mtb_pkg::slot_fld_t  slot;
  mtb_pkg::dur_t       duration;
  mtb_pkg::kind_t      repeat_kind;

  modport source (output valid, mode, slot, duration, repeat_kind, input ready);
  modport sink   (input valid, mode, slot, duration, repeat_kind, output ready);
endinterface

interface mtb_res_if;
  logic                valid;
  logic                ready;
  mtb_pkg::status_t    status;
  mtb_pkg::slot_fld_t  result_slot;
  mtb_pkg::time_t      time_now;
  logic                last;

  modport source (output valid, status, result_slot, time_now, last, input ready);
  modport sink   (input valid, status, result_slot, time_now, last, output ready);
endinterface

interface mtb_cfg_if;
  logic            valid;
  logic            ready;
  mtb_pkg::step_t  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/multi_timer_bank.sv
// ---------------------------------------------------------------------------
// multi_timer_bank
// Bank of timer slots: create, start, stop, free and tick requests.
// ---------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  in_ch   | in  | valid / ready   | mode, slot, duration, repeat_kind
//  out_ch  | out | valid / ready   | status, result_slot, time_now, last
//  cfg_ch  | in  | valid / ready   | data (tick step)
//
//  Create, start, stop and free are accepted in S_IDLE, then executed in S_EXEC.
//  A tick adds the step to the time, then the scan reads one slot per cycle
//  while no expiring slot waits on the output, then gives the tick-done result.
//  Reset is synchronous; it clears the slot-in-use flags, the time counter
//  and sets the tick step to 1000. No clearing pass is needed.
//  A waiting result stalls execution of all but a tick; the scan pauses on an expiring slot.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_timer_bank #(
  parameter int unsigned NUM_SLOTS = mtb_pkg::NUM_SLOTS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  mtb_cmd_if.sink   in_ch,
  mtb_res_if.source out_ch,
  mtb_cfg_if.sink   cfg_ch
);
  import mtb_pkg::*;

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state_r, state_nxt;
  mode_t                mode_r;
  slot_fld_t            slot_r;
  dur_t                 dur_r;
  kind_t                kind_r;
  time_t                now_r, now_nxt;
  step_t                step_r;
  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic [SLOT_W-1:0]    e_r, e_nxt;

  logic                 out_valid_r;
  status_t              out_status_r;
  slot_fld_t            out_slot_r;
  time_t                out_time_r;
  logic                 out_last_r;

  logic                 accept;
  logic                 out_free;
  logic                 out_ld;
  status_t              ld_status;
  slot_fld_t            ld_slot;
  logic                 ld_last;

  logic [SLOT_W-1:0]    slot_idx;
  logic                 slot_ok;
  logic [SLOT_W-1:0]    free_idx;
  logic                 free_found;

  slot_wr_t             wr;
  logic [SLOT_W-1:0]    wr_addr;
  logic [SLOT_W-1:0]    rd_addr;
  kind_t                rd_kind;
  timer_ent_t           rd_tmr;
  logic                 hit;
  logic                 last_slot;

  mtb_slot_mem #(.NUM_SLOTS(NUM_SLOTS)) u_mem (
    .clk     (clk),
    .wr_addr (wr_addr),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_kind (rd_kind),
    .rd_tmr  (rd_tmr)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign slot_idx  = SLOT_W'(slot_r);
  assign slot_ok   = (int'(slot_r) < NUM_SLOTS) && used_r[slot_idx];
  assign hit       = used_r[e_r] && (rd_tmr.interval != '0) && !(rd_tmr.expiry > now_r);
  assign last_slot = (e_r == SLOT_W'(NUM_SLOTS - 1));

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    now_nxt   = now_r;
    used_nxt  = used_r;
    e_nxt     = e_r;
    out_ld    = 1'b0;
    ld_status = ST_OK;
    ld_slot   = '0;
    ld_last   = 1'b0;
    wr        = '0;
    wr_addr   = slot_idx;
    rd_addr   = e_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (mode_r == MODE_TICK) begin
          now_nxt   = now_r + TIME_W'(step_r);
          e_nxt     = '0;
          rd_addr   = '0;
          state_nxt = S_SCAN;
        end else if (out_free) begin
          out_ld    = 1'b1;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
          case (mode_r)
            MODE_CREATE: begin
              if (free_found) begin
                used_nxt[free_idx] = 1'b1;
                wr.kind_we = 1'b1;
                wr.tmr_we  = 1'b1;
                wr.kind    = kind_r;
                wr_addr    = free_idx;
                ld_slot    = SLOT_FW'(free_idx);
              end else begin
                ld_status = ST_ERR;
              end
            end
            MODE_START: begin
              if (slot_ok) begin
                wr.tmr_we          = 1'b1;
                wr.tmr.expiry      = now_r + TIME_W'(dur_r);
                wr.tmr.interval    = dur_r;
              end else begin
                ld_status = ST_ERR;
              end
            end
            MODE_STOP: begin
              if (slot_ok) begin
                wr.tmr_we = 1'b1;
              end else begin
                ld_status = ST_ERR;
              end
            end
            MODE_FREE: begin
              if (slot_ok) begin
                used_nxt[slot_idx] = 1'b0;
              end else begin
                ld_status = ST_ERR;
              end
            end
            default: begin
              ld_status = ST_ERR;
            end
          endcase
        end
      end
      S_SCAN: begin
        wr_addr = e_r;
        if (!hit || out_free) begin
          if (hit) begin
            out_ld    = 1'b1;
            ld_status = ST_EXPIRED;
            ld_slot   = SLOT_FW'(e_r);
            case (rd_kind)
              KIND_ONE_SHOT: begin
                wr.tmr_we = 1'b1;
              end
              KIND_AUTO_FREE: begin
                used_nxt[e_r] = 1'b0;
              end
              KIND_LOOP: begin
                wr.tmr_we       = 1'b1;
                wr.tmr.expiry   = now_r + TIME_W'(rd_tmr.interval);
                wr.tmr.interval = rd_tmr.interval;
              end
              default: begin
              end
            endcase
          end
          if (last_slot) begin
            state_nxt = S_DONE;
          end else begin
            // prefetch the next slot while this one is written back
            e_nxt   = e_r + SLOT_W'(1);
            rd_addr = e_r + SLOT_W'(1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_ld    = 1'b1;
          ld_status = ST_DONE;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      used_r      <= '0;
      e_r         <= '0;
      step_r      <= STEP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      now_r   <= now_nxt;
      used_r  <= used_nxt;
      e_r     <= e_nxt;
      if (cfg_ch.valid) begin
        step_r <= cfg_ch.data;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the request and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_ch.mode;
      slot_r <= in_ch.slot;
      dur_r  <= in_ch.duration;
      kind_r <= in_ch.repeat_kind;
    end
    if (out_ld) begin
      out_status_r <= ld_status;
      out_slot_r   <= ld_slot;
      out_time_r   <= now_r;
      out_last_r   <= ld_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.result_slot = out_slot_r;
  assign out_ch.time_now    = out_time_r;
  assign out_ch.last        = out_last_r;

  `ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_r == S_EXEC, "request not executed")
  `ASSERT_IMPLIES(a_done_last, clk, rst_n, out_valid_r && out_status_r == ST_DONE, out_last_r, "tick done without last")
  `ASSERT_IMPLIES(a_exp_not_last, clk, rst_n, out_valid_r && out_status_r == ST_EXPIRED, !out_last_r, "expired result marked last")
  `ASSERT_IMPLIES(a_exp_used, clk, rst_n, out_ld && state_r == S_SCAN, used_r[e_r], "expiry from unused slot")

endmodule

// File: rtl/mtb_slot_mem.sv
// ---------------------------------------------------------------------------
// mtb_slot_mem
// Per-slot kind and timer memories, one write and one registered read port.
// ---------------------------------------------------------------------------
module mtb_slot_mem #(
  parameter int unsigned NUM_SLOTS = mtb_pkg::NUM_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
  input  mtb_pkg::slot_wr_t            wr,
  input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
  output mtb_pkg::kind_t               rd_kind,
  output mtb_pkg::timer_ent_t          rd_tmr
);
  import mtb_pkg::*;

  kind_t      kind_mem [NUM_SLOTS];
  timer_ent_t tmr_mem  [NUM_SLOTS];

  kind_t      rd_kind_r;
  timer_ent_t rd_tmr_r;

  always_ff @(posedge clk) begin
    if (wr.kind_we) begin
      kind_mem[wr_addr] <= wr.kind;
    end
    if (wr.tmr_we) begin
      tmr_mem[wr_addr] <= wr.tmr;
    end
  end

  always_ff @(posedge clk) begin
    rd_kind_r <= kind_mem[rd_addr];
    rd_tmr_r  <= tmr_mem[rd_addr];
  end

  assign rd_kind = rd_kind_r;
  assign rd_tmr  = rd_tmr_r;

endmodule
